// ===== design/pcr_pkg.sv =====
// package: constants and types for the parallel comb reverb
package pcr_pkg;

   localparam int MAX_DELAY_DEF  = 4096;
   localparam int COMB_WIDTH_DEF = 24;
   localparam int DELAY_W        = 12;
   localparam int GAIN_W         = 15;
   localparam int WET_W          = 7;
   localparam int SAMPLE_W       = 16;
   localparam int FGAIN_W        = 17;

   localparam logic [GAIN_W-1:0] GAIN_OFS_B = 15'd4302;
   localparam logic [GAIN_W-1:0] GAIN_OFS_C = 15'd8988;
   localparam logic [GAIN_W-1:0] GAIN_OFS_D = 15'd10158;
   localparam logic [WET_W-1:0]  WET_FULL   = 7'd100;

   localparam int CSR_ADDR_W = 3;
   localparam logic [CSR_ADDR_W-1:0] REG_DELAY_A = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_DELAY_B = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_DELAY_C = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_DELAY_D = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_GAIN    = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] REG_WET     = 3'd5;

   localparam logic [DELAY_W-1:0] DELAY_A_RST = 12'd2400;
   localparam logic [DELAY_W-1:0] DELAY_B_RST = 12'd1837;
   localparam logic [DELAY_W-1:0] DELAY_C_RST = 12'd3327;
   localparam logic [DELAY_W-1:0] DELAY_D_RST = 12'd2017;
   localparam logic [GAIN_W-1:0]  GAIN_RST    = 15'd22938;
   localparam logic [WET_W-1:0]   WET_RST     = 7'd30;

   localparam int CSR_DATA_W = 16;

endpackage

// ===== design/parallel_comb_reverb.sv =====
// top level: four parallel feedback comb filters with dry/wet mix
//  channel  | direction | handshake
//  req_     | in        | req_valid / req_stall
//  rsp_     | out       | rsp_valid / rsp_stall
//  csr_     | in        | csr_valid / csr_ready
// after reset the delay memories are cleared, one entry a cycle, all MAX_DELAY entries
// each comb runs address, memory read, load, 17 multiply steps and write,
// then two mix steps, COMB_WIDTH+10 = 34 divide steps and one saturate step;
// rsp_valid then rises, and no new sample is taken until that result is out
// the comb multiplier works one gain bit per cycle; the mix divider one quotient bit per cycle
// a result waiting on rsp_stall blocks the next sample only until it is taken
module parallel_comb_reverb #(
   parameter int MAX_DELAY  = pcr_pkg::MAX_DELAY_DEF,
   parameter int COMB_WIDTH = pcr_pkg::COMB_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [pcr_pkg::SAMPLE_W-1:0] req_in_sample,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [pcr_pkg::SAMPLE_W-1:0] rsp_out_sample,
   output logic                              rsp_out_clipped,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [pcr_pkg::CSR_ADDR_W-1:0]    csr_index,
   input  logic [pcr_pkg::CSR_DATA_W-1:0]    csr_data
);
   localparam int AW   = $clog2(MAX_DELAY);
   localparam int CW   = COMB_WIDTH;
   localparam int GW   = pcr_pkg::FGAIN_W;
   localparam int PW   = CW + GW;
   localparam int SUMW = CW + 2;
   localparam int MIXW = SUMW + 8;
   localparam int BCW  = $clog2(MIXW + 1);

   localparam logic signed [PW:0] YMAX = $signed({{(PW-CW+2){1'b0}}, {(CW-1){1'b1}}});
   localparam logic signed [PW:0] YMIN = ~YMAX;

   localparam logic [3:0] ST_CLEAR = 4'd0;
   localparam logic [3:0] ST_IDLE  = 4'd1;
   localparam logic [3:0] ST_RADDR = 4'd2;
   localparam logic [3:0] ST_RDATA = 4'd3;
   localparam logic [3:0] ST_MUL   = 4'd4;
   localparam logic [3:0] ST_COMB  = 4'd5;
   localparam logic [3:0] ST_MIXA  = 4'd6;
   localparam logic [3:0] ST_MIXB  = 4'd7;
   localparam logic [3:0] ST_DIV   = 4'd8;
   localparam logic [3:0] ST_SAT   = 4'd9;
   localparam logic [3:0] ST_OUT   = 4'd10;
   localparam logic [3:0] ST_RWAIT = 4'd11;

   logic [pcr_pkg::DELAY_W-1:0] delay_a_ff, delay_b_ff, delay_c_ff, delay_d_ff;
   logic [pcr_pkg::GAIN_W-1:0]  gain_ff;
   logic [pcr_pkg::WET_W-1:0]   wet_ff;

   logic [3:0]    state_ff;
   logic [AW-1:0] clr_ff, widx_ff;
   logic [1:0]    k_ff;
   logic [BCW-1:0] bit_ff;
   logic signed [pcr_pkg::SAMPLE_W-1:0] x_ff;
   logic signed [CW-1:0] line_q_ff;
   logic signed [GW-1:0] g_ff;
   logic [GW-1:0] gsh_ff;
   logic signed [PW-1:0] acc_ff;
   logic signed [SUMW-1:0] sum_ff;
   logic clip_ff;
   logic signed [MIXW-1:0] mix_ff;
   logic mneg_ff;
   logic [MIXW-1:0] quo_ff;
   logic [7:0] rem_ff;
   logic signed [pcr_pkg::SAMPLE_W-1:0] out_ff;
   logic oclip_ff;

   logic signed [CW-1:0] mem_a [MAX_DELAY];
   logic signed [CW-1:0] mem_b [MAX_DELAY];
   logic signed [CW-1:0] mem_c [MAX_DELAY];
   logic signed [CW-1:0] mem_d [MAX_DELAY];
   logic signed [CW-1:0] rd_a_ff, rd_b_ff, rd_c_ff, rd_d_ff;
   logic [AW-1:0] raddr_ff;

   logic req_xfer;
   logic mem_we;
   logic [AW-1:0] waddr;
   logic signed [CW-1:0] wdata;
   logic [pcr_pkg::DELAY_W-1:0] dsel;
   logic [AW-1:0] dmod;
   logic [pcr_pkg::GAIN_W-1:0] ofs;
   logic signed [PW-1:0] part;
   logic signed [PW-1:0] fb;
   logic signed [PW:0] ysum;
   logic signed [CW-1:0] ysat;
   logic yclip;
   logic [pcr_pkg::WET_W-1:0] wet_eff;
   logic signed [MIXW-1:0] mix_term;
   logic [8:0] rem_try;
   logic signed [MIXW:0] qs;

   function automatic logic [pcr_pkg::WET_W-1:0] WET_FULL_SUB(
      input logic [pcr_pkg::WET_W-1:0] w);
      return pcr_pkg::WET_FULL - w;
   endfunction

   assign req_xfer  = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = (state_ff == ST_OUT);
   assign rsp_out_sample  = out_ff;
   assign rsp_out_clipped = oclip_ff;
   assign wet_eff = (wet_ff > pcr_pkg::WET_FULL) ? pcr_pkg::WET_FULL : wet_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_a_ff <= pcr_pkg::DELAY_A_RST;
         delay_b_ff <= pcr_pkg::DELAY_B_RST;
         delay_c_ff <= pcr_pkg::DELAY_C_RST;
         delay_d_ff <= pcr_pkg::DELAY_D_RST;
         gain_ff    <= pcr_pkg::GAIN_RST;
         wet_ff     <= pcr_pkg::WET_RST;
      end else if (csr_valid) begin
         case (csr_index)
            pcr_pkg::REG_DELAY_A: delay_a_ff <= csr_data[pcr_pkg::DELAY_W-1:0];
            pcr_pkg::REG_DELAY_B: delay_b_ff <= csr_data[pcr_pkg::DELAY_W-1:0];
            pcr_pkg::REG_DELAY_C: delay_c_ff <= csr_data[pcr_pkg::DELAY_W-1:0];
            pcr_pkg::REG_DELAY_D: delay_d_ff <= csr_data[pcr_pkg::DELAY_W-1:0];
            pcr_pkg::REG_GAIN:    gain_ff    <= csr_data[pcr_pkg::GAIN_W-1:0];
            pcr_pkg::REG_WET:     wet_ff     <= csr_data[pcr_pkg::WET_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (k_ff)
         2'd0: begin dsel = delay_a_ff; ofs = '0; end
         2'd1: begin dsel = delay_b_ff; ofs = pcr_pkg::GAIN_OFS_B; end
         2'd2: begin dsel = delay_c_ff; ofs = pcr_pkg::GAIN_OFS_C; end
         default: begin dsel = delay_d_ff; ofs = pcr_pkg::GAIN_OFS_D; end
      endcase
      dmod = AW'(dsel);
   end

   // shift-add multiply: one gain bit a cycle, top bit has negative weight
   always_comb begin
      part = gsh_ff[0] ? (PW'(line_q_ff) <<< bit_ff) : '0;
      if (bit_ff == BCW'(GW - 1)) part = -part;
   end

   assign fb   = acc_ff >>> 15;
   assign ysum = (PW+1)'(x_ff) + (PW+1)'(fb);
   always_comb begin
      yclip = 1'b0;
      ysat  = CW'(ysum);
      if (ysum > YMAX) begin
         yclip = 1'b1; ysat = {1'b0, {(CW-1){1'b1}}};
      end else if (ysum < YMIN) begin
         yclip = 1'b1; ysat = {1'b1, {(CW-1){1'b0}}};
      end
   end

   assign mem_we = (state_ff == ST_CLEAR) || (state_ff == ST_COMB);
   assign waddr  = (state_ff == ST_CLEAR) ? clr_ff : widx_ff;
   assign wdata  = (state_ff == ST_CLEAR) ? '0 : ysat;

   always_ff @(posedge clock) begin
      if (mem_we && (state_ff == ST_CLEAR || k_ff == 2'd0)) mem_a[waddr] <= wdata;
      if (mem_we && (state_ff == ST_CLEAR || k_ff == 2'd1)) mem_b[waddr] <= wdata;
      if (mem_we && (state_ff == ST_CLEAR || k_ff == 2'd2)) mem_c[waddr] <= wdata;
      if (mem_we && (state_ff == ST_CLEAR || k_ff == 2'd3)) mem_d[waddr] <= wdata;
      rd_a_ff <= mem_a[raddr_ff];
      rd_b_ff <= mem_b[raddr_ff];
      rd_c_ff <= mem_c[raddr_ff];
      rd_d_ff <= mem_d[raddr_ff];
   end

   assign mix_term = (state_ff == ST_MIXA)
      ? MIXW'($signed({1'b0, WET_FULL_SUB(wet_eff)})) * MIXW'(x_ff)
      : MIXW'($signed({1'b0, wet_eff})) * MIXW'(sum_ff);

   // restoring divide of |mix| by 100, one quotient bit a cycle
   assign rem_try = {rem_ff, quo_ff[MIXW-1]} - 9'd100;
   assign qs = mneg_ff ? -(MIXW+1)'(quo_ff) : (MIXW+1)'(quo_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         widx_ff  <= '0;
         k_ff     <= '0;
      end else begin
         case (state_ff)
            ST_CLEAR: begin
               clr_ff <= clr_ff + AW'(1);
               if (clr_ff == AW'(MAX_DELAY - 1)) state_ff <= ST_IDLE;
            end
            ST_IDLE: if (req_xfer) begin
               x_ff <= req_in_sample;
               sum_ff <= '0;
               clip_ff <= 1'b0;
               k_ff <= '0;
               state_ff <= ST_RADDR;
            end
            ST_RADDR: begin
               raddr_ff <= widx_ff - dmod;
               g_ff <= GW'(gain_ff) - GW'(ofs);
               state_ff <= ST_RWAIT;
            end
            // memory output register catches up with the new address
            ST_RWAIT: state_ff <= ST_RDATA;
            ST_RDATA: state_ff <= ST_MUL;
            ST_MUL: begin
               acc_ff <= acc_ff + part;
               gsh_ff <= gsh_ff >> 1;
               bit_ff <= bit_ff + BCW'(1);
               if (bit_ff == BCW'(GW - 1)) state_ff <= ST_COMB;
            end
            ST_COMB: begin
               sum_ff <= sum_ff + SUMW'(ysat);
               clip_ff <= clip_ff | yclip;
               k_ff <= k_ff + 2'd1;
               if (k_ff == 2'd3) begin
                  widx_ff <= widx_ff + AW'(1);
                  state_ff <= ST_MIXA;
               end else state_ff <= ST_RADDR;
            end
            ST_MIXA: begin
               mix_ff <= mix_term;
               state_ff <= ST_MIXB;
            end
            ST_MIXB: begin
               mneg_ff <= (mix_ff + mix_term) < 0;
               quo_ff <= ((mix_ff + mix_term) < 0) ? MIXW'(-(mix_ff + mix_term))
                                                  : MIXW'(mix_ff + mix_term);
               rem_ff <= '0;
               bit_ff <= '0;
               state_ff <= ST_DIV;
            end
            ST_DIV: begin
               if (!rem_try[8]) begin
                  rem_ff <= rem_try[7:0];
                  quo_ff <= {quo_ff[MIXW-2:0], 1'b1};
               end else begin
                  rem_ff <= {rem_ff[6:0], quo_ff[MIXW-1]};
                  quo_ff <= {quo_ff[MIXW-2:0], 1'b0};
               end
               bit_ff <= bit_ff + BCW'(1);
               if (bit_ff == BCW'(MIXW - 1)) state_ff <= ST_SAT;
            end
            ST_SAT: begin
               if (qs > (MIXW+1)'(32767)) begin
                  out_ff <= 16'sh7fff; oclip_ff <= 1'b1;
               end else if (qs < -(MIXW+1)'(32768)) begin
                  out_ff <= 16'sh8000; oclip_ff <= 1'b1;
               end else begin
                  out_ff <= qs[pcr_pkg::SAMPLE_W-1:0]; oclip_ff <= clip_ff;
               end
               state_ff <= ST_OUT;
            end
            ST_OUT: if (!rsp_stall) state_ff <= ST_IDLE;
            default: state_ff <= ST_IDLE;
         endcase
         if (state_ff == ST_RDATA) begin
            acc_ff <= '0;
            bit_ff <= '0;
            gsh_ff <= g_ff;
            case (k_ff)
               2'd0: line_q_ff <= rd_a_ff;
               2'd1: line_q_ff <= rd_b_ff;
               2'd2: line_q_ff <= rd_c_ff;
               default: line_q_ff <= rd_d_ff;
            endcase
         end
      end
   end
endmodule

// ===== design/pcr_checker.sv =====
// checker: port-level properties of the parallel comb reverb, bound to the top level
module pcr_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_stall,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic signed [15:0] rsp_out_sample,
   input logic rsp_out_clipped
);
   // one sample in flight: no new transfer while a result is pending
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(req_valid && !req_stall)) else $error("input taken while result pending");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_sample))
      else $error("stalled result changed");

   // an offered result carries defined sample and flag bits
   a_rsp_known: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !$isunknown({rsp_out_sample, rsp_out_clipped}))
      else $error("result has unknown bits");

   a_after_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall |=> !rsp_valid) else $error("result repeated");
endmodule

bind parallel_comb_reverb pcr_checker u_pcr_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_out_sample(rsp_out_sample),
   .rsp_out_clipped(rsp_out_clipped)
);

// ===== tb/sv/parallel_comb_reverb_checker.sv =====
// checker: predicts the reverb output per sample and compares the responses
module parallel_comb_reverb_checker
   import pcr_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_stall,
   input  logic signed [SAMPLE_W-1:0] req_in_sample,
   input  logic                       rsp_valid,
   input  logic                       rsp_stall,
   input  logic signed [SAMPLE_W-1:0] rsp_out_sample,
   input  logic                       rsp_out_clipped,
   input  logic                       csr_valid,
   input  logic                       csr_ready,
   input  logic [CSR_ADDR_W-1:0]      csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_data,
   output int                         fail_count,
   output int                         pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       clipped;
   } mix_result_type;

   logic signed [COMB_WIDTH_DEF-1:0] comb_mem [4][MAX_DELAY_DEF];
   logic [DELAY_W-1:0] wr_ptr;
   logic [DELAY_W-1:0] comb_delay [4];
   logic [GAIN_W-1:0]  base_gain;
   logic [WET_W-1:0]   wet_share;
   mix_result_type     mix_queue[$];

   function automatic longint saturate(longint v, int bits, inout bit clip);
      longint hi;
      longint lo;
      hi = (longint'(1) <<< (bits - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) begin
         clip = 1;
         return hi;
      end
      if (v < lo) begin
         clip = 1;
         return lo;
      end
      return v;
   endfunction

   function automatic longint run_comb(int k, longint gain, longint x, inout bit clip);
      logic [DELAY_W-1:0] rd_ptr;
      longint fb;
      longint y;
      rd_ptr = wr_ptr - comb_delay[k];
      // arithmetic shift floors toward minus infinity
      fb = (gain * longint'(comb_mem[k][rd_ptr])) >>> 15;
      y = saturate(x + fb, COMB_WIDTH_DEF, clip);
      comb_mem[k][wr_ptr] = y[COMB_WIDTH_DEF-1:0];
      return y;
   endfunction

   function automatic mix_result_type predict_mix(logic signed [SAMPLE_W-1:0] dry);
      bit             clip;
      longint         x;
      longint         g;
      longint         wet;
      longint         sum;
      longint         mix;
      mix_result_type res;
      clip = 0;
      x = dry;
      g = base_gain;
      wet = (wet_share > WET_FULL) ? 100 : wet_share;
      sum = run_comb(0, g, x, clip);
      sum += run_comb(1, g - GAIN_OFS_B, x, clip);
      sum += run_comb(2, g - GAIN_OFS_C, x, clip);
      sum += run_comb(3, g - GAIN_OFS_D, x, clip);
      wr_ptr = wr_ptr + 1'b1;
      mix = ((100 - wet) * x + wet * sum) / 100;
      mix = saturate(mix, SAMPLE_W, clip);
      res.sample = mix[SAMPLE_W-1:0];
      res.clipped = clip;
      return res;
   endfunction

   always @(posedge clock) begin
      mix_result_type want;
      if (reset) begin
         for (int k = 0; k < 4; k++)
            for (int i = 0; i < MAX_DELAY_DEF; i++) comb_mem[k][i] = '0;
         wr_ptr = '0;
         comb_delay[0] = DELAY_A_RST;
         comb_delay[1] = DELAY_B_RST;
         comb_delay[2] = DELAY_C_RST;
         comb_delay[3] = DELAY_D_RST;
         base_gain = GAIN_RST;
         wet_share = WET_RST;
         mix_queue.delete();
         fail_count = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_DELAY_A: comb_delay[0] = csr_data[DELAY_W-1:0];
               REG_DELAY_B: comb_delay[1] = csr_data[DELAY_W-1:0];
               REG_DELAY_C: comb_delay[2] = csr_data[DELAY_W-1:0];
               REG_DELAY_D: comb_delay[3] = csr_data[DELAY_W-1:0];
               REG_GAIN:    base_gain = csr_data[GAIN_W-1:0];
               REG_WET:     wet_share = csr_data[WET_W-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (mix_queue.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%t unexpected response: sample %0d clipped %0b", $realtime,
                           rsp_out_sample, rsp_out_clipped);
            end else begin
               want = mix_queue.pop_front();
               if (want.sample !== rsp_out_sample || want.clipped !== rsp_out_clipped) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("%t mismatch: sample exp %0d act %0d, clipped exp %0b act %0b",
                              $realtime, want.sample, rsp_out_sample, want.clipped,
                              rsp_out_clipped);
               end
            end
         end
         if (req_valid && !req_stall) mix_queue.push_back(predict_mix(req_in_sample));
      end
      pending_count = mix_queue.size();
   end

endmodule

// ===== tb/sv/parallel_comb_reverb_test.sv =====
// testbench top: clock, reset, stimulus phases and the final verdict
module parallel_comb_reverb_test;
   import pcr_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   logic signed [SAMPLE_W-1:0] req_in_sample;
   logic                       rsp_valid;
   logic                       rsp_stall;
   logic signed [SAMPLE_W-1:0] rsp_out_sample;
   logic                       rsp_out_clipped;
   logic                       csr_valid;
   logic                       csr_ready;
   logic [CSR_ADDR_W-1:0]      csr_index;
   logic [CSR_DATA_W-1:0]      csr_data;
   int                         fail_count;
   int                         pending_count;

   int send_idle_pct;
   int recv_stall_pct;
   int hold_cycles;

   parallel_comb_reverb u_dut (.*);

   parallel_comb_reverb_checker u_checker (.*);

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_cycles <= hold_cycles - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   task automatic write_csr(logic [CSR_ADDR_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
   endtask

   // block must be idle: nothing expected, then let the last sample drain
   task automatic configure(int da, int db, int dc, int dd, int g, int w);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      // random upper bits are ignored by the block
      write_csr(REG_DELAY_A, {4'($urandom_range(15)), 12'(da)});
      write_csr(REG_DELAY_B, {4'($urandom_range(15)), 12'(db)});
      write_csr(REG_DELAY_C, {4'($urandom_range(15)), 12'(dc)});
      write_csr(REG_DELAY_D, {4'($urandom_range(15)), 12'(dd)});
      write_csr(REG_GAIN, {1'($urandom_range(1)), 15'(g)});
      write_csr(REG_WET, {9'($urandom), 7'(w)});
      csr_valid <= 1'b0;
   endtask

   task automatic send_sample(logic signed [SAMPLE_W-1:0] x);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_in_sample <= x;
      do @(posedge clock); while (req_stall);
   endtask

   function automatic logic signed [SAMPLE_W-1:0] rand_sample();
      case ($urandom_range(5))
         0: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
         1, 2: return 16'($signed(8'($urandom)));
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic int rand_delay();
      case ($urandom_range(9))
         0: return $urandom_range(1) ? 0 : 4095;
         1: return $urandom_range(4095);
         default: return $urandom_range(1, 40);
      endcase
   endfunction

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_in_sample = '0;
      rsp_stall = 1'b0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_cycles = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // reset settings: early samples pass straight through the combs
      send_sample(16'sh7fff);
      send_sample(16'sh8000);
      send_sample(16'sh0000);
      send_sample(16'shffff);
      send_sample(16'sh0001);
      // short delays at full gain and full wet drive the output into saturation
      configure(1, 2, 3, 5, 32767, 100);
      repeat (8) send_sample(16'sh7fff);
      repeat (4) send_sample(16'sh8000);
      // delay zero, longest delay, zero gain gives negative comb gains, all dry
      configure(0, 4095, 1, 0, 0, 0);
      send_sample(16'sh8000);
      send_sample(16'sh7fff);
      send_sample(16'sh5555);
      send_sample(16'shaaaa);
      // wet above one hundred
      configure(1, 1, 2, 2, 20000, 127);
      send_sample(16'sh7fff);
      send_sample(16'sh8000);
      send_sample(16'sh1234);

      for (int ph = 0; ph < 8; ph++) begin
         int w;
         case ($urandom_range(3))
            0: w = 0;
            1: w = 100;
            2: w = $urandom_range(101, 127);
            default: w = $urandom_range(100);
         endcase
         configure(rand_delay(), rand_delay(), rand_delay(), rand_delay(),
                   ($urandom_range(3) == 0) ? $urandom_range(1) * 32767
                                            : $urandom_range(32767), w);
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
            default: begin send_idle_pct = 16; recv_stall_pct = 16; end
         endcase
         if (ph == 4) hold_cycles = 600;
         for (int i = 0; i < 200; i++) begin
            if (ph == 5 && i == 100) begin
               req_valid <= 1'b0;
               @(posedge clock);
               while (pending_count != 0) @(posedge clock);
            end
            send_sample(rand_sample());
         end
      end
      req_valid <= 1'b0;

      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("parallel_comb_reverb_test: PASS");
      else
         $display("parallel_comb_reverb_test: FAIL");
      $finish;
   end

   initial begin
      #20ms;
      $display("parallel_comb_reverb_test: FAIL");
      $finish;
   end

endmodule
